### src/first_fit_coalescing_allocator_unit_defines.svh
// assertion macros for the allocator rtl
// expects signals named clock and reset in the module that uses them
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define FFCA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define FFCA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/ffca_pkg.sv
// shared types and codes for the first-fit coalescing allocator
// used by ffca_cell and first_fit_coalescing_allocator_unit, no dependencies
`timescale 1ns / 1ps

package ffca_pkg;

   // width of the size and address fields of an item
   localparam int REQ_W = 10;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] ST_BAD_FREE   = 2'd2;

   // operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      OP_NONE        = 3'd0,
      OP_MATCH_ALLOC = 3'd1,
      OP_MATCH_FREE  = 3'd2,
      OP_ALLOC       = 3'd3,
      OP_FREE_MARK   = 3'd4,
      OP_MERGE_PREV  = 3'd5
   } cell_op_type;

   // command group driven by the sequencer to all cells
   typedef struct packed {
      cell_op_type      op;
      logic [REQ_W-1:0] want;
      logic [REQ_W-1:0] addr;
      logic             split;
      logic             merge_next;
   } cell_cmd_type;

endpackage

### src/ffca_cell.sv
// one block-table cell of the allocator chain: start, size, free and valid flags
// depends on ffca_pkg for the command struct and operation codes
`timescale 1ns / 1ps

module ffca_cell #(
   parameter int SIZE_W       = 11,
   parameter int ARENA_BYTES  = 1024,
   parameter int HEADER_BYTES = 32,
   parameter bit HEAD_CELL    = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ffca_pkg::cell_cmd_type cmd,
   input  logic                  sel,
   input  logic                  prev_sel,
   input  logic                  next_sel,
   input  logic                  above,
   input  logic                  prev_valid,
   input  logic                  prev_free,
   input  logic [SIZE_W-1:0]     prev_start,
   input  logic [SIZE_W-1:0]     prev_size,
   input  logic                  next_valid,
   input  logic                  next_free,
   input  logic [SIZE_W-1:0]     next_start,
   input  logic [SIZE_W-1:0]     next_size,
   output logic                  valid,
   output logic                  free,
   output logic [SIZE_W-1:0]     start,
   output logic [SIZE_W-1:0]     size,
   output logic                  hit
);

   localparam logic [SIZE_W-1:0] HDR      = SIZE_W'(HEADER_BYTES);
   localparam logic [SIZE_W-1:0] INIT_SZ  = SIZE_W'(ARENA_BYTES - HEADER_BYTES);

   logic              valid_ff, valid_in;
   logic              free_ff, free_in;
   logic [SIZE_W-1:0] start_ff, start_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              hit_ff, hit_in;
   logic [SIZE_W-1:0] want_ext;
   logic [SIZE_W-1:0] addr_ext;
   logic              strictly_above;

   assign want_ext       = SIZE_W'(cmd.want);
   assign addr_ext       = SIZE_W'(cmd.addr);
   assign strictly_above = above & ~sel;

   // next state of the cell for the broadcast operation
   always_comb begin
      valid_in = valid_ff;
      free_in  = free_ff;
      start_in = start_ff;
      size_in  = size_ff;
      hit_in   = hit_ff;
      case (cmd.op)
         ffca_pkg::OP_MATCH_ALLOC: begin
            hit_in = valid_ff & free_ff & (size_ff >= want_ext);
         end
         ffca_pkg::OP_MATCH_FREE: begin
            hit_in = valid_ff & ~free_ff & ((start_ff + HDR) == addr_ext);
         end
         ffca_pkg::OP_ALLOC: begin
            if (sel) begin
               free_in = 1'b0;
               if (cmd.split) begin
                  size_in = want_ext;
               end
            end else if (cmd.split && strictly_above) begin
               if (prev_sel) begin
                  // remainder of the split block
                  valid_in = 1'b1;
                  free_in  = 1'b1;
                  start_in = prev_start + HDR + want_ext;
                  size_in  = prev_size - want_ext - HDR;
               end else begin
                  // open a slot: shift up by one
                  valid_in = prev_valid;
                  free_in  = prev_free;
                  start_in = prev_start;
                  size_in  = prev_size;
               end
            end
         end
         ffca_pkg::OP_FREE_MARK: begin
            if (sel) begin
               free_in = 1'b1;
               if (cmd.merge_next) begin
                  size_in = size_ff + HDR + next_size;
               end
            end else if (cmd.merge_next && strictly_above) begin
               // close the slot of the absorbed next block
               valid_in = next_valid;
               free_in  = next_free;
               start_in = next_start;
               size_in  = next_size;
            end
         end
         ffca_pkg::OP_MERGE_PREV: begin
            if (next_sel) begin
               size_in = size_ff + HDR + next_size;
            end else if (above) begin
               valid_in = next_valid;
               free_in  = next_free;
               start_in = next_start;
               size_in  = next_size;
            end
         end
         default: begin
            hit_in = hit_ff;
         end
      endcase
   end

   // cell registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= HEAD_CELL;
         free_ff  <= HEAD_CELL;
         start_ff <= '0;
         size_ff  <= HEAD_CELL ? INIT_SZ : '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         free_ff  <= free_in;
         start_ff <= start_in;
         size_ff  <= size_in;
         hit_ff   <= hit_in;
      end
   end

   assign valid = valid_ff;
   assign free  = free_ff;
   assign start = start_ff;
   assign size  = size_ff;
   assign hit   = hit_ff;

endmodule

### src/first_fit_coalescing_allocator_unit.sv
// First-fit allocator with coalescing over a fixed arena. The block table lives in a chain of
// MAX_BLOCKS cells, kept in address order, each holding one block's start, payload size and
// free flag. An item is taken only while the sequencer is idle; it then runs a parallel match
// in all cells, a first-fit pick across the chain, a gather of the picked block, and an update
// that shifts the chain by one cell; a free that also merges with the block below it adds a
// second shift-down step, and the result then waits in S_DONE until the output register is
// free, so no new item is taken before the previous result has entered the output register.
// depends on ffca_pkg, ffca_cell and first_fit_coalescing_allocator_unit_defines.svh
`timescale 1ns / 1ps
`include "first_fit_coalescing_allocator_unit_defines.svh"

module first_fit_coalescing_allocator_unit #(
   parameter int ARENA_BYTES  = 1024,
   parameter int HEADER_BYTES = 32,
   parameter int MAX_BLOCKS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // request_size [9:0], address [19:10], zero [23:20]
   input  logic        req_tuser,   // kind [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status [1:0], payload_offset [11:2],
                                    // free_bytes [21:12], zero [23:22]
);

   localparam int RW = ffca_pkg::REQ_W;
   localparam int AW = $clog2(ARENA_BYTES) + 1;
   localparam int SW = (AW > RW + 1) ? AW : RW + 1;
   localparam logic [SW-1:0] HDR     = SW'(HEADER_BYTES);
   localparam logic [SW-1:0] INIT_SZ = SW'(ARENA_BYTES - HEADER_BYTES);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_MATCH  = 7'b0000010,
      S_SELECT = 7'b0000100,
      S_GATHER = 7'b0001000,
      S_APPLY  = 7'b0010000,
      S_MERGE  = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic                   kind_ff;
   logic [RW-1:0]          want_ff;
   logic [RW-1:0]          addr_ff;
   logic [MAX_BLOCKS-1:0]  sel_ff, sel_in;
   logic [MAX_BLOCKS-1:0]  above_ff, above_in;
   logic                   found_ff, found_in;
   logic [SW-1:0]          g_start_ff, g_start_in;
   logic [SW-1:0]          g_size_ff, g_size_in;
   logic                   nfree_ff, nfree_in;
   logic                   pfree_ff, pfree_in;
   logic                   full_ff, full_in;
   logic [SW-1:0]          avail_ff, avail_in;
   logic [1:0]             res_status_ff, res_status_in;
   logic [SW-1:0]          res_offset_ff, res_offset_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0]            rsp_tdata_ff, rsp_tdata_in;

   ffca_pkg::cell_cmd_type cmd;
   logic                   req_fire;
   logic                   out_free;
   logic [SW-1:0]          want_ext;
   logic                   split_c;
   logic                   ok_alloc;
   logic                   ok_free;

   logic [MAX_BLOCKS-1:0]  c_valid;
   logic [MAX_BLOCKS-1:0]  c_free;
   logic [MAX_BLOCKS-1:0]  c_hit;
   logic [MAX_BLOCKS-1:0]  c_vf;
   logic [SW-1:0]          c_start [MAX_BLOCKS];
   logic [SW-1:0]          c_size  [MAX_BLOCKS];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;
   assign want_ext   = SW'(want_ff);
   assign c_vf       = c_valid & c_free;

   // request decisions from the gathered block
   assign split_c  = (g_size_ff > (want_ext + HDR)) & ~full_ff;
   assign ok_alloc = (kind_ff == ffca_pkg::KIND_ALLOC) & (want_ff != '0) &
                     (want_ext <= avail_ff) & found_ff;
   assign ok_free  = (kind_ff == ffca_pkg::KIND_FREE) & found_ff;

   // command broadcast to the chain
   always_comb begin
      cmd.op         = ffca_pkg::OP_NONE;
      cmd.want       = want_ff;
      cmd.addr       = addr_ff;
      cmd.split      = split_c;
      cmd.merge_next = nfree_ff;
      case (state_ff)
         S_MATCH: begin
            cmd.op = (kind_ff == ffca_pkg::KIND_ALLOC) ? ffca_pkg::OP_MATCH_ALLOC
                                                       : ffca_pkg::OP_MATCH_FREE;
         end
         S_APPLY: begin
            if (ok_alloc) begin
               cmd.op = ffca_pkg::OP_ALLOC;
            end else if (ok_free) begin
               cmd.op = ffca_pkg::OP_FREE_MARK;
            end
         end
         S_MERGE: begin
            cmd.op = ffca_pkg::OP_MERGE_PREV;
         end
         default: begin
            cmd.op = ffca_pkg::OP_NONE;
         end
      endcase
   end

   // chain of block cells with neighbor links
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      logic          p_sel, p_valid, p_free;
      logic [SW-1:0] p_start, p_size;
      logic          n_sel, n_valid, n_free;
      logic [SW-1:0] n_start, n_size;

      if (i == 0) begin : g_lo
         assign p_sel   = 1'b0;
         assign p_valid = 1'b0;
         assign p_free  = 1'b0;
         assign p_start = '0;
         assign p_size  = '0;
      end else begin : g_lo
         assign p_sel   = sel_ff[i-1];
         assign p_valid = c_valid[i-1];
         assign p_free  = c_free[i-1];
         assign p_start = c_start[i-1];
         assign p_size  = c_size[i-1];
      end

      if (i == MAX_BLOCKS - 1) begin : g_hi
         assign n_sel   = 1'b0;
         assign n_valid = 1'b0;
         assign n_free  = 1'b0;
         assign n_start = '0;
         assign n_size  = '0;
      end else begin : g_hi
         assign n_sel   = sel_ff[i+1];
         assign n_valid = c_valid[i+1];
         assign n_free  = c_free[i+1];
         assign n_start = c_start[i+1];
         assign n_size  = c_size[i+1];
      end

      ffca_cell #(
         .SIZE_W       (SW),
         .ARENA_BYTES  (ARENA_BYTES),
         .HEADER_BYTES (HEADER_BYTES),
         .HEAD_CELL    (i == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .sel        (sel_ff[i]),
         .prev_sel   (p_sel),
         .next_sel   (n_sel),
         .above      (above_ff[i]),
         .prev_valid (p_valid),
         .prev_free  (p_free),
         .prev_start (p_start),
         .prev_size  (p_size),
         .next_valid (n_valid),
         .next_free  (n_free),
         .next_start (n_start),
         .next_size  (n_size),
         .valid      (c_valid[i]),
         .free       (c_free[i]),
         .start      (c_start[i]),
         .size       (c_size[i]),
         .hit        (c_hit[i])
      );
   end

   // first-fit pick and gather of the picked cell
   always_comb begin
      sel_in     = sel_ff;
      found_in   = found_ff;
      above_in   = above_ff;
      g_start_in = g_start_ff;
      g_size_in  = g_size_ff;
      nfree_in   = nfree_ff;
      pfree_in   = pfree_ff;
      full_in    = full_ff;
      if (state_ff == S_SELECT) begin
         // lowest set hit bit
         sel_in   = c_hit & (~c_hit + MAX_BLOCKS'(1));
         found_in = |c_hit;
      end
      if (state_ff == S_GATHER) begin
         above_in   = ~(sel_ff - MAX_BLOCKS'(1));
         g_start_in = '0;
         g_size_in  = '0;
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            g_start_in = g_start_in | (sel_ff[i] ? c_start[i] : '0);
            g_size_in  = g_size_in  | (sel_ff[i] ? c_size[i]  : '0);
         end
         nfree_in = |(sel_ff & (c_vf >> 1));
         pfree_in = |(sel_ff & (c_vf << 1));
         full_in  = c_valid[MAX_BLOCKS-1];
      end
   end

   // free count and result of the request
   always_comb begin
      avail_in      = avail_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      if (state_ff == S_APPLY) begin
         res_offset_in = '0;
         if (kind_ff == ffca_pkg::KIND_ALLOC) begin
            res_status_in = ok_alloc ? ffca_pkg::ST_OK : ffca_pkg::ST_ALLOC_FAIL;
            if (ok_alloc) begin
               res_offset_in = g_start_ff + HDR;
               avail_in      = avail_ff - (split_c ? (want_ext + HDR) : g_size_ff);
            end
         end else begin
            res_status_in = ok_free ? ffca_pkg::ST_OK : ffca_pkg::ST_BAD_FREE;
            if (ok_free) begin
               avail_in = avail_ff + g_size_ff + (nfree_ff ? HDR : '0) +
                          (pfree_ff ? HDR : '0);
            end
         end
      end
   end

   // sequencer and output register
   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_SELECT;
         end
         S_SELECT: begin
            state_in = S_GATHER;
         end
         S_GATHER: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in = (ok_free && pfree_ff) ? S_MERGE : S_DONE;
         end
         S_MERGE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, avail_ff[RW-1:0], res_offset_ff[RW-1:0],
                                res_status_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sel_ff        <= '0;
         above_ff      <= '0;
         found_ff      <= 1'b0;
         avail_ff      <= INIT_SZ;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sel_ff        <= sel_in;
         above_ff      <= above_in;
         found_ff      <= found_in;
         avail_ff      <= avail_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_tuser;
         want_ff <= req_tdata[RW-1:0];
         addr_ff <= req_tdata[2*RW-1:RW];
      end
      g_start_ff    <= g_start_in;
      g_size_ff     <= g_size_in;
      nfree_ff      <= nfree_in;
      pfree_ff      <= pfree_in;
      full_ff       <= full_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // checks on the chain and sequencer
   `FFCA_ASSERT_NOW(a_sel_onehot0, 1'b1, $onehot0(sel_ff), "more than one cell picked")
   `FFCA_ASSERT_NOW(a_valid_prefix, 1'b1, ((c_valid & (c_valid + MAX_BLOCKS'(1))) == '0), "valid cells not contiguous from the bottom")
   `FFCA_ASSERT_NOW(a_head_valid, 1'b1, c_valid[0], "bottom cell lost its block")
   `FFCA_ASSERT_NOW(a_avail_bound, 1'b1, (avail_ff <= INIT_SZ), "free count above arena payload")
   `FFCA_ASSERT_NEXT(a_accept_match, req_fire, (state_ff == S_MATCH), "accepted item did not start a match")

endmodule
